@@ hdl/whs_pkg.sv @@
`timescale 1ns / 1ps
package whs_pkg;

   // datapath width of the cordic x/y words (inputs are prescaled to 2^39)
   localparam int CORDIC_W     = 44;
   localparam int CORDIC_STEPS = 28;
   localparam int RATIO_BITS   = 20;

   typedef logic [31:0] turn_type;

   // arctan(2^-i) in units of 2*pi/2^32
   function automatic turn_type atan_turn(input int idx);
      turn_type v;
      case (idx)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         24: v = 32'h00000029;
         25: v = 32'h00000014;
         26: v = 32'h0000000A;
         27: v = 32'h00000005;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/whs_cordic.sv @@
`timescale 1ns / 1ps
module whs_cordic import whs_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           in_valid,
   input  logic signed [COORD_BITS:0]     dx,
   input  logic signed [COORD_BITS:0]     dy,
   output logic                           out_valid,
   output logic [ANGLE_BITS-1:0]          ang,
   output logic [CORDIC_W-1:0]            len
);

   localparam int PRESCALE = 39 - COORD_BITS;
   localparam turn_type ROUND_ADD = turn_type'(1) << (31 - ANGLE_BITS);

   logic signed [CORDIC_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff [0:CORDIC_STEPS];
   turn_type                   z_ff [0:CORDIC_STEPS];
   logic                       zero_ff [0:CORDIC_STEPS];
   logic                       vld_ff [0:CORDIC_STEPS];

   logic signed [CORDIC_W-1:0] x0_in, y0_in;
   turn_type                   z0_in;
   logic                       zero0_in;

   logic                       out_vld_ff;
   logic [ANGLE_BITS-1:0]      ang_ff;
   logic [CORDIC_W-1:0]        len_ff;
   turn_type                   zr;

   // prescale and half-turn prerotation
   always_comb begin
      logic signed [CORDIC_W-1:0] xs, ys;
      xs = CORDIC_W'(dx) <<< PRESCALE;
      ys = CORDIC_W'(dy) <<< PRESCALE;
      zero0_in = (dx == '0) && (dy == '0);
      if (xs < 0) begin
         x0_in = -xs;
         y0_in = -ys;
         z0_in = 32'h80000000;
      end else begin
         x0_in = xs;
         y0_in = ys;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= zero0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (enable) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + atan_turn(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - atan_turn(i);
            end
            zero_ff[i+1] <= zero_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   assign zr = z_ff[CORDIC_STEPS] + ROUND_ADD;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (zero_ff[CORDIC_STEPS]) begin
            ang_ff <= '0;
            len_ff <= '0;
         end else begin
            ang_ff <= zr[31 -: ANGLE_BITS];
            len_ff <= x_ff[CORDIC_STEPS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (enable) begin
         out_vld_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign ang       = ang_ff;
   assign len       = len_ff;

endmodule

@@ hdl/waypoint_heading_select_core.sv @@
`timescale 1ns / 1ps
// pipeline: two 30-stage cordic vectoring pipes in parallel, one bisector stage,
//   21 divider stages, one multiply stage, one output register
// throughput: one request per cycle; the whole pipe halts while a result waits
// reset: synchronous, clears all valid bits and loads the threshold register with 2086
module waypoint_heading_select_core import whs_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   // prev_x, prev_y, mid_x, mid_y, next_x, next_y, 16 bits each from bit 0 up
   input  logic [95:0] req_tdata,
   // result side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // heading [15:0], nearly_straight [16], zero fill [23:17]
   output logic [23:0] rsp_tdata,
   // threshold register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int AB        = ANGLE_BITS;
   localparam int DIV_STEPS = RATIO_BITS + 1;
   localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
   localparam logic [AB-1:0] HALF    = AB'(1) << (AB - 1);

   typedef struct packed {
      logic [AB-1:0] temp;
      logic [AB-1:0] a2;
      logic [AB-1:0] g;
      logic          ns;
      logic          l1gt;
      logic          l2gt;
      logic          lzero;
   } side_type;

   // fold an angle difference into [0, half turn]
   function automatic logic [AB-1:0] fold(input logic [AB-1:0] d);
      return (d > HALF) ? (AB'(0) - d) : d;
   endfunction

   // sign-extend a coordinate field from COORD_BITS bits
   function automatic logic signed [COORD_BITS:0] coord(input logic [15:0] f);
      logic [31:0]                   w;
      logic signed [COORD_BITS-1:0]  c;
      w = 32'(f);
      c = w[COORD_BITS-1:0];
      return (COORD_BITS+1)'(c);
   endfunction

   // pipe advances whenever the output register is free or being taken
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // threshold register
   logic [15:0] thresh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= 16'd2086;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // difference vectors at the middle waypoint
   logic signed [COORD_BITS:0] dx1, dy1, dx2, dy2;
   assign dx1 = coord(req_tdata[15:0])  - coord(req_tdata[47:32]);
   assign dy1 = coord(req_tdata[31:16]) - coord(req_tdata[63:48]);
   assign dx2 = coord(req_tdata[79:64]) - coord(req_tdata[47:32]);
   assign dy2 = coord(req_tdata[95:80]) - coord(req_tdata[63:48]);

   logic                 c1_vld, c2_vld;
   logic [AB-1:0]        a1, a2;
   logic [CORDIC_W-1:0]  l1, l2;

   // bearing back to the previous waypoint
   whs_cordic #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(AB)) u_cordic_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (req_tvalid),
      .dx        (dx1),
      .dy        (dy1),
      .out_valid (c1_vld),
      .ang       (a1),
      .len       (l1)
   );

   // bearing forward to the next waypoint
   whs_cordic #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(AB)) u_cordic_fwd (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (req_tvalid),
      .dx        (dx2),
      .dy        (dy2),
      .out_valid (c2_vld),
      .ang       (a2),
      .len       (l2)
   );

   // bisector stage: turned bisector, straight test, skew base and segment order
   side_type            s1_side_in;
   logic [CORDIC_W-1:0] s1_lmax_in, s1_diff_in;

   always_comb begin
      logic [AB:0]   sum;
      logic [AB-1:0] b;
      logic [AB-1:0] tmp;
      logic          gt1, gt2;
      sum = {1'b0, a1} + {1'b0, a2};
      b   = sum[AB:1];
      tmp = (a1 < a2) ? (b + QUARTER) : (b - QUARTER);
      gt1 = l1 > l2;
      gt2 = l2 > l1;
      s1_side_in.temp  = tmp;
      s1_side_in.a2    = a2;
      s1_side_in.g     = fold(a2 - tmp);
      s1_side_in.ns    = 32'(fold(a1 - a2)) < 32'(thresh_ff);
      s1_side_in.l1gt  = gt1;
      s1_side_in.l2gt  = gt2;
      s1_lmax_in       = gt1 ? l1 : l2;
      s1_diff_in       = gt1 ? (l1 - l2) : (l2 - l1);
      s1_side_in.lzero = (s1_lmax_in == '0);
   end

   // divider pipe: entry 0 is the bisector stage, one quotient bit per stage after it
   side_type                  side_ff [0:DIV_STEPS];
   logic [CORDIC_W-1:0]       lmax_ff [0:DIV_STEPS];
   logic [CORDIC_W-1:0]       rem_ff  [0:DIV_STEPS];
   logic [RATIO_BITS:0]       q_ff    [0:DIV_STEPS];
   logic                      vld_ff  [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= s1_side_in;
         lmax_ff[0] <= s1_lmax_in;
         rem_ff[0]  <= s1_diff_in;
         q_ff[0]    <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= c1_vld && c2_vld;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      logic [CORDIC_W-1:0] trial;
      logic                take;
      if (k == 1) begin : g_first
         assign trial = rem_ff[0];
      end else begin : g_rest
         assign trial = rem_ff[k-1] << 1;
      end
      assign take = trial >= lmax_ff[k-1];

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_ff[k-1];
            lmax_ff[k] <= lmax_ff[k-1];
            rem_ff[k]  <= take ? (trial - lmax_ff[k-1]) : trial;
            q_ff[k]    <= {q_ff[k-1][RATIO_BITS-1:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // multiply stage: skew = g * ratio / 2^20
   logic [RATIO_BITS:0]      ratio;
   logic [AB+RATIO_BITS:0]   prod;
   side_type                 mul_side_ff;
   logic [AB-1:0]            skew_ff;
   logic [RATIO_BITS:0]      ratio_ff;
   logic                     mul_vld_ff;

   assign ratio = side_ff[DIV_STEPS].lzero ? '0 : q_ff[DIV_STEPS];
   assign prod  = (AB+RATIO_BITS+1)'(side_ff[DIV_STEPS].g) * (AB+RATIO_BITS+1)'(ratio);

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_side_ff <= side_ff[DIV_STEPS];
         skew_ff     <= prod[RATIO_BITS +: AB];
         ratio_ff    <= ratio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (adv) begin
         mul_vld_ff <= vld_ff[DIV_STEPS];
      end
   end

   // side selection: temp if nearly straight or equal, else side of longer segment
   logic [AB-1:0] res_in;
   always_comb begin
      logic [AB-1:0] am, ap, pm, pp;
      am = mul_side_ff.temp - skew_ff;
      ap = mul_side_ff.temp + skew_ff;
      pm = fold(mul_side_ff.a2 - am);
      pp = fold(mul_side_ff.a2 - ap);
      if (mul_side_ff.ns) begin
         res_in = mul_side_ff.temp;
      end else if (mul_side_ff.l1gt) begin
         res_in = (pp > pm) ? am : ap;
      end else if (mul_side_ff.l2gt) begin
         res_in = (pp > pm) ? ap : am;
      end else begin
         res_in = mul_side_ff.temp;
      end
   end

   // output register
   logic [15:0] heading_ff;
   logic        ns_ff;
   logic        out_vld_ff;
   logic [31:0] res_wide;
   assign res_wide = 32'(res_in);

   always_ff @(posedge clock) begin
      if (adv) begin
         heading_ff <= res_wide[15:0];
         ns_ff      <= mul_side_ff.ns;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= mul_vld_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, ns_ff, heading_ff};

`ifndef SYNTHESIS
   // the ratio never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff |-> (ratio_ff <= ((RATIO_BITS+1)'(1) << RATIO_BITS)))
      else $error("skew ratio above one");

   // the skew never exceeds the folded angle it scales
   assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff |-> (skew_ff <= mul_side_ff.g))
      else $error("skew larger than base angle");

   // coincident segments give no skew
   assert property (@(posedge clock) disable iff (reset)
      (mul_vld_ff && mul_side_ff.lzero) |-> (skew_ff == '0))
      else $error("skew with zero length");

   // both bearing pipes stay in step
   assert property (@(posedge clock) disable iff (reset)
      c1_vld == c2_vld)
      else $error("cordic pipes out of step");
`endif

endmodule
